@@ design/iff_pkg.sv @@
package iff_pkg;

    localparam int CNT_BITS_DFLT = 32;
    localparam int OUT_CNT_W     = 32;
    localparam int BUDGET_W      = 18;
    localparam int IN_DATA_W     = 136;
    localparam int OUT_DATA_W    = 200;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [15:0] ETYPE_IPV4       = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6       = 16'h86DD;
    localparam logic [15:0] MIN_ETH_BYTES    = 16'd14;
    localparam logic [15:0] MIN_IP6_BYTES    = 16'd54;
    localparam logic [15:0] MIN_IP4_BYTES    = 16'd34;
    localparam logic [16:0] ETH_HDR_BYTES    = 17'd14;
    localparam logic [3:0]  IHL_NO_OPTIONS   = 4'd5;
    localparam logic [15:0] MIN_TOO_BIG_TLEN = 16'd28;
    localparam logic [2:0]  TLEN_ALIGN_LOW   = 3'd4;
    localparam logic [63:0] WINDOW_NS        = 64'd1_000_000_000;

    typedef enum logic [1:0] {
        VERDICT_PASS  = 2'd0,
        VERDICT_DROP  = 2'd1,
        VERDICT_ABORT = 2'd2,
        VERDICT_TX    = 2'd3
    } t_verdict;

    typedef enum logic [3:0] {
        REASON_NONE        = 4'd0,
        REASON_ETH_SHORT   = 4'd1,
        REASON_IP6_SHORT   = 4'd2,
        REASON_IP6_LISTED  = 4'd3,
        REASON_NON_IP      = 4'd4,
        REASON_IP_LENGTH   = 4'd5,
        REASON_OPTIONS     = 4'd6,
        REASON_RESERVED    = 4'd7,
        REASON_IP_LISTED   = 4'd8,
        REASON_FRAGMENT    = 4'd9,
        REASON_BAD_PAYLOAD = 4'd10,
        REASON_REPLY_SENT  = 4'd11
    } t_reason;

    typedef enum logic [1:0] {
        CFG_DROP_FRAG    = 2'd0,
        CFG_SEND_TOO_BIG = 2'd1,
        CFG_REPLY_RATE   = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [15:0] frame_length;
        logic [15:0] ether_type;
        logic [3:0]  header_words;
        logic [15:0] total_length;
        logic [15:0] fragment_word;
        logic        v4_source_listed;
        logic        v6_source_listed;
        logic [63:0] now_ns;
    } t_item;

    typedef struct packed {
        logic frame;
        logic header;
        logic v4;
        logic v6;
        logic frag;
        logic reply;
    } t_bump;

    typedef struct packed {
        t_verdict                   verdict;
        t_reason                    reason;
        t_bump                      bump;
        logic                       restart;
        logic                       budget_we;
        logic signed [BUDGET_W-1:0] budget_next;
    } t_decision;

    typedef struct packed {
        logic [OUT_CNT_W-1:0] replies_sent;
        logic [OUT_CNT_W-1:0] fragment_drops;
        logic [OUT_CNT_W-1:0] v6_listed_drops;
        logic [OUT_CNT_W-1:0] v4_listed_drops;
        logic [OUT_CNT_W-1:0] header_errors;
        logic [OUT_CNT_W-1:0] frame_errors;
    } t_counts;

endpackage

@@ design/iff_decide.sv @@
module iff_decide
    import iff_pkg::*;
(
    input  t_item                       i_item,
    input  logic                        i_drop_frag,
    input  logic                        i_send_too_big,
    input  logic [CFG_DATA_W-1:0]       i_reply_rate,
    input  logic [63:0]                 i_window_start,
    input  logic signed [BUDGET_W-1:0]  i_budget,
    output t_decision                   o_dec
);

    logic [63:0]                w_elapsed;
    logic [16:0]                w_tlen_eth;
    logic                       w_reply_path;
    logic                       w_restart;
    logic signed [BUDGET_W-1:0] w_base;
    logic                       w_bad_payload;

    assign w_elapsed     = i_item.now_ns - i_window_start;
    assign w_tlen_eth    = {1'b0, i_item.total_length} + ETH_HDR_BYTES;
    assign w_reply_path  = i_send_too_big && (i_item.fragment_word[12:0] == 13'd0)
                           && i_item.fragment_word[13];
    assign w_restart     = w_elapsed > WINDOW_NS;
    assign w_base        = w_restart ? $signed({2'b00, i_reply_rate}) : i_budget;
    assign w_bad_payload = (i_item.total_length < MIN_TOO_BIG_TLEN)
                           || (i_item.total_length[2:0] != TLEN_ALIGN_LOW);

    always_comb begin
        o_dec             = '0;
        o_dec.verdict     = VERDICT_PASS;
        o_dec.reason      = REASON_NONE;
        o_dec.budget_next = w_base;
        if (i_item.frame_length < MIN_ETH_BYTES) begin
            o_dec.verdict    = VERDICT_ABORT;
            o_dec.reason     = REASON_ETH_SHORT;
            o_dec.bump.frame = 1'b1;
        end else if (i_item.ether_type == ETYPE_IPV6) begin
            if (i_item.frame_length < MIN_IP6_BYTES) begin
                o_dec.verdict    = VERDICT_ABORT;
                o_dec.reason     = REASON_IP6_SHORT;
                o_dec.bump.frame = 1'b1;
            end else if (i_item.v6_source_listed) begin
                o_dec.verdict = VERDICT_DROP;
                o_dec.reason  = REASON_IP6_LISTED;
                o_dec.bump.v6 = 1'b1;
            end
        end else if (i_item.ether_type != ETYPE_IPV4) begin
            o_dec.reason = REASON_NON_IP;
        end else if (i_item.frame_length < MIN_IP4_BYTES) begin
            o_dec.verdict    = VERDICT_ABORT;
            o_dec.reason     = REASON_IP_LENGTH;
            o_dec.bump.frame = 1'b1;
        end else if (i_item.header_words != IHL_NO_OPTIONS) begin
            o_dec.verdict     = VERDICT_DROP;
            o_dec.reason      = REASON_OPTIONS;
            o_dec.bump.header = 1'b1;
        end else if (w_tlen_eth > {1'b0, i_item.frame_length}) begin
            o_dec.verdict     = VERDICT_ABORT;
            o_dec.reason      = REASON_IP_LENGTH;
            o_dec.bump.header = 1'b1;
        end else if (i_item.fragment_word[15]) begin
            o_dec.verdict     = VERDICT_DROP;
            o_dec.reason      = REASON_RESERVED;
            o_dec.bump.header = 1'b1;
        end else if (i_item.v4_source_listed) begin
            o_dec.verdict = VERDICT_DROP;
            o_dec.reason  = REASON_IP_LISTED;
            o_dec.bump.v4 = 1'b1;
        end else if (i_drop_frag && (i_item.fragment_word[13:0] != 14'd0)) begin
            o_dec.bump.frag = 1'b1;
            o_dec.verdict   = VERDICT_DROP;
            o_dec.reason    = REASON_FRAGMENT;
            if (w_reply_path) begin
                o_dec.restart   = w_restart;
                o_dec.budget_we = w_restart;
                if (w_restart || (i_budget > 0)) begin
                    if (w_bad_payload) begin
                        o_dec.reason      = REASON_BAD_PAYLOAD;
                        o_dec.bump.header = 1'b1;
                    end else begin
                        o_dec.verdict     = VERDICT_TX;
                        o_dec.reason      = REASON_REPLY_SENT;
                        o_dec.bump.reply  = 1'b1;
                        o_dec.budget_we   = 1'b1;
                        o_dec.budget_next = w_base - 18'sd1;
                    end
                end
            end
        end
    end

endmodule

@@ design/iff_stats.sv @@
module iff_stats
    import iff_pkg::*;
#(
    parameter int COUNTER_BITS = CNT_BITS_DFLT
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_commit,
    input  t_bump   i_bump,
    output t_counts o_next
);

    localparam int NUM_CNT = 6;

    logic [COUNTER_BITS-1:0] r_cnt [NUM_CNT];
    logic [COUNTER_BITS-1:0] n_cnt [NUM_CNT];
    logic [NUM_CNT-1:0]      w_inc;

    assign w_inc = {i_bump.reply, i_bump.frag, i_bump.v6,
                    i_bump.v4, i_bump.header, i_bump.frame};

    always_comb begin
        for (int k = 0; k < NUM_CNT; k++) begin
            n_cnt[k] = r_cnt[k] + COUNTER_BITS'(w_inc[k] & i_commit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CNT; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            for (int k = 0; k < NUM_CNT; k++) begin
                r_cnt[k] <= n_cnt[k];
            end
        end
    end

    assign o_next.frame_errors    = OUT_CNT_W'(n_cnt[0]);
    assign o_next.header_errors   = OUT_CNT_W'(n_cnt[1]);
    assign o_next.v4_listed_drops = OUT_CNT_W'(n_cnt[2]);
    assign o_next.v6_listed_drops = OUT_CNT_W'(n_cnt[3]);
    assign o_next.fragment_drops  = OUT_CNT_W'(n_cnt[4]);
    assign o_next.replies_sent    = OUT_CNT_W'(n_cnt[5]);

endmodule

@@ design/ingress_fragment_filter.sv @@
// Channel  | Dir | Beat contents
// s_axis   | in  | one packet's parsed header fields, drop-list flags, timestamp
// m_axis   | out | verdict, reason and the six counters after this packet
// cfg      | in  | register write: drop_fragments, send_too_big, replies_per_second
//
// One beat per cycle in each direction while m_axis is not stalled; a decision
// passes from its input beat through the input register, then the result register.
// The decision, counter update and reply-window update sit between those two
// registers. Reset clears configuration, counters, window and both valids.
// A stalled result holds; the input register still takes a beat while the
// result register drains in the same cycle.
module ingress_fragment_filter
    import iff_pkg::*;
#(
    parameter int COUNTER_BITS = CNT_BITS_DFLT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // frame_length, ether_type, header_words, total_length, fragment_word,
    // v4_source_listed, v6_source_listed, now_ns, zero pad
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // verdict, reason, frame_errors, header_errors, v4_listed_drops,
    // v6_listed_drops, fragment_drops, replies_sent, zero pad
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_item                      w_item;
    t_decision                  w_dec;
    t_counts                    w_counts;
    logic                       w_advance;

    logic                       r_in_valid;
    t_item                      r_item;
    logic                       r_out_valid;
    t_verdict                   r_verdict;
    t_reason                    r_reason;
    t_counts                    r_counts;
    logic                       r_drop_frag;
    logic                       r_send_too_big;
    logic [CFG_DATA_W-1:0]      r_reply_rate;
    logic [63:0]                r_win_start;
    logic signed [BUDGET_W-1:0] r_budget;

    assign w_item.frame_length     = s_axis_tdata[15:0];
    assign w_item.ether_type       = s_axis_tdata[31:16];
    assign w_item.header_words     = s_axis_tdata[35:32];
    assign w_item.total_length     = s_axis_tdata[51:36];
    assign w_item.fragment_word    = s_axis_tdata[67:52];
    assign w_item.v4_source_listed = s_axis_tdata[68];
    assign w_item.v6_source_listed = s_axis_tdata[69];
    assign w_item.now_ns           = s_axis_tdata[133:70];

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    iff_decide u_decide (
        .i_item         (r_item),
        .i_drop_frag    (r_drop_frag),
        .i_send_too_big (r_send_too_big),
        .i_reply_rate   (r_reply_rate),
        .i_window_start (r_win_start),
        .i_budget       (r_budget),
        .o_dec          (w_dec)
    );

    iff_stats #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_stats (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (w_advance),
        .i_bump   (w_dec.bump),
        .o_next   (w_counts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_frag    <= 1'b0;
            r_send_too_big <= 1'b0;
            r_reply_rate   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DROP_FRAG:    r_drop_frag    <= i_cfg_data[0];
                CFG_SEND_TOO_BIG: r_send_too_big <= i_cfg_data[0];
                CFG_REPLY_RATE:   r_reply_rate   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_win_start <= '0;
            r_budget    <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_advance && w_dec.restart) begin
                r_win_start <= r_item.now_ns;
            end
            if (w_advance && w_dec.budget_we) begin
                r_budget <= w_dec.budget_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item <= w_item;
        end
        if (w_advance) begin
            r_verdict <= w_dec.verdict;
            r_reason  <= w_dec.reason;
            r_counts  <= w_counts;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_counts, r_reason, r_verdict};

endmodule
